// ----- rtl/assert_macros.svh -----
// Assertion macros shared by fodt_queue and fodt_engine.
// No dependencies; each user supplies aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FODT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FODT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fodt_pkg.sv -----
// Shared types and constants for the file-open dedup table.
// No dependencies.
package fodt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam logic [63:0] HASH_SEED   = 64'd5381;
    localparam logic [63:0] HASH_BEGIN  = HASH_SEED * 64'd33;
    localparam logic [63:0] WINDOW_RST  = 64'd60000000000;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_OPEN_BEGIN = 2'd0,
        REQ_PATH_BYTE  = 2'd1,
        REQ_OPEN_END   = 2'd2,
        REQ_EXIT       = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        RPT_FIRST   = 2'd0,
        RPT_EXPIRED = 2'd1,
        RPT_EXIT    = 2'd2
    } rpt_kind_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [22:0]        pid;
        logic [7:0]         path_byte;
        logic signed [31:0] open_flags;
        logic [63:0]        event_time_ns;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         report_kind;
        logic [22:0]        report_pid;
        logic signed [31:0] report_flags;
        logic [31:0]        open_count;
        logic [63:0]        key_hash;
        logic [63:0]        report_time_ns;
        logic               untracked;
        logic               last;
    } out_item_t;

    // Command handed from front to engine.
    typedef struct packed {
        logic               is_exit;
        logic [22:0]        pid;
        logic [63:0]        key;
        logic signed [31:0] flags;
        logic [63:0]        time_ns;
    } cmd_t;

    typedef struct packed {
        logic [63:0]        hash;
        logic [63:0]        time_ns;
        logic [31:0]        count;
        logic [22:0]        pid;
        logic signed [31:0] flags;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_MV,
        ST_SR_RD,
        ST_SR_CHK,
        ST_INSERT,
        ST_XR_RD,
        ST_XR_CHK,
        ST_XD_RD,
        ST_XD_CHK,
        ST_XD_MV,
        ST_FLUSH
    } eng_state_t;

endpackage

// ----- rtl/file_open_dedup_table_unit.sv -----
// Top level of the file-open dedup table: front, command queue, engine.
// Depends on fodt_pkg, fodt_front, fodt_queue, fodt_engine.
//
// Deduplicates file-open requests in a table keyed by a djb2 hash of pid and
// path. open_begin and path byte requests are folded into the running hash in
// the front end and are taken one per cycle while the command queue has room.
// open_end and process exit become table commands that go through a two-entry
// queue to the engine, which walks the table through a single-port memory with
// registered read: an open_end runs an expiry sweep, which drops each expired
// entry by moving the last entry into its slot, then a key search, and an
// insert if no key matched; an exit runs a report pass and then a removal pass
// that moves the last entry into each removed slot. Each command ends in a
// flush state that marks the final result, if any, with last. Results leave
// through an output register with one more held result behind it, so the
// engine keeps working while the consumer stalls. window_ns is written through
// cfg_wr_en/cfg_wr_data and should only change while idle.
module file_open_dedup_table_unit #(
    parameter int TABLE_DEPTH = fodt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  fodt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fodt_pkg::out_item_t m_data
);
    import fodt_pkg::*;

    logic q_push, q_ready, q_pop, q_valid;
    cmd_t push_cmd, pop_cmd;

    fodt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_cmd   (push_cmd),
        .q_ready (q_ready)
    );

    fodt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (q_valid)
    );

    fodt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ----- rtl/fodt_front.sv -----
// Front end: takes requests, folds the djb2 hash, forwards table commands.
// Depends on fodt_pkg.
module fodt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fodt_pkg::in_item_t s_data,
    output logic              q_push,
    output fodt_pkg::cmd_t    q_cmd,
    input  logic              q_ready
);
    import fodt_pkg::*;

    logic [63:0] hash_reg, hash_next;
    logic [22:0] pid_reg, pid_next;
    logic        accept;
    logic [63:0] byte_ext;

    assign s_ready  = q_ready;
    assign accept   = s_valid && s_ready;
    assign byte_ext = {{56{s_data.path_byte[7]}}, s_data.path_byte};

    always_comb begin
        hash_next = hash_reg;
        pid_next  = pid_reg;
        q_push    = 1'b0;
        if (accept) begin
            unique case (req_type_t'(s_data.req_type))
                REQ_OPEN_BEGIN: begin
                    pid_next  = s_data.pid;
                    hash_next = HASH_BEGIN + {41'd0, s_data.pid};
                end
                REQ_PATH_BYTE: begin
                    if (s_data.path_byte != 8'd0) begin
                        hash_next = {hash_reg[58:0], 5'd0} + hash_reg + byte_ext;
                    end
                end
                REQ_OPEN_END: q_push = 1'b1;
                REQ_EXIT:     q_push = 1'b1;
                default:      q_push = 1'b0;
            endcase
        end
    end

    always_comb begin
        q_cmd.is_exit = (s_data.req_type == REQ_EXIT);
        q_cmd.pid     = (s_data.req_type == REQ_EXIT) ? s_data.pid : pid_reg;
        q_cmd.key     = hash_reg;
        q_cmd.flags   = s_data.open_flags;
        q_cmd.time_ns = s_data.event_time_ns;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_SEED;
            pid_reg  <= 23'd0;
        end else begin
            hash_reg <= hash_next;
            pid_reg  <= pid_next;
        end
    end

endmodule

// ----- rtl/fodt_queue.sv -----
// Short command queue between front and engine.
// Depends on fodt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fodt_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fodt_pkg::cmd_t push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output fodt_pkg::cmd_t pop_cmd,
    output logic           pop_valid
);
    import fodt_pkg::*;

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t             slot_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign push_ready = (cnt_reg != CNT_W'(CMD_QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `FODT_ASSERT_NOW(a_no_overflow, push, push_ready, "queue push while full")
    `FODT_ASSERT_NOW(a_no_underflow, pop, pop_valid, "queue pop while empty")
    `FODT_ASSERT_NEXT(a_push_shows, push && !pop, pop_valid, "pushed command not visible")

endmodule

// ----- rtl/fodt_engine.sv -----
// Back end: table memory and sweep/search/insert/exit sequencer with result buffer.
// Depends on fodt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fodt_engine #(
    parameter int TABLE_DEPTH = fodt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data,
    input  logic                q_valid,
    input  fodt_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output fodt_pkg::out_item_t m_data
);
    import fodt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t     mem [TABLE_DEPTH];
    entry_t     rd_data_reg;
    logic       rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t     wr_data;

    eng_state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next, used_reg, used_next;
    logic [CNT_W-1:0] last_pos;
    cmd_t       cur_reg, cur_next;
    logic [63:0] window_reg;
    out_item_t  pend_reg, pend_next, out_reg, out_next, emit_item;
    logic       pend_valid_reg, pend_valid_next, out_valid_reg, out_valid_next;
    logic       out_free, emit_ok, emit_fire;
    logic       expired, pid_hit;
    logic [63:0] age;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign last_pos = CNT_W'(used_reg - 1'b1);
    assign age      = cur_reg.time_ns - rd_data_reg.time_ns;
    assign expired  = (age > window_reg);
    assign pid_hit  = (rd_data_reg.pid == cur_reg.pid);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;
        emit_fire       = 1'b0;
        emit_item.report_kind    = RPT_EXPIRED;
        emit_item.report_pid     = rd_data_reg.pid;
        emit_item.report_flags   = rd_data_reg.flags;
        emit_item.open_count     = rd_data_reg.count;
        emit_item.key_hash       = rd_data_reg.hash;
        emit_item.report_time_ns = cur_reg.time_ns;
        emit_item.untracked      = 1'b0;
        emit_item.last           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cur_next   = q_cmd;
                    idx_next   = '0;
                    state_next = q_cmd.is_exit ? ST_XR_RD : ST_SW_RD;
                end
            end
            // expiry sweep
            ST_SW_RD: begin
                if (idx_reg >= used_reg) begin
                    idx_next   = '0;
                    state_next = ST_SR_RD;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SW_CHK;
                end
            end
            ST_SW_CHK: begin
                if (!expired) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SW_RD;
                end else if (!(rd_data_reg.count > 32'd1) || emit_ok) begin
                    emit_fire = (rd_data_reg.count > 32'd1);
                    if (idx_reg == last_pos) begin
                        used_next  = last_pos;
                        state_next = ST_SW_RD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = last_pos[IDX_W-1:0];
                        state_next = ST_SW_MV;
                    end
                end
            end
            ST_SW_MV: begin
                wr_en      = 1'b1;
                used_next  = last_pos;
                state_next = ST_SW_RD;
            end
            // key search
            ST_SR_RD: begin
                if (idx_reg >= used_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SR_CHK;
                end
            end
            ST_SR_CHK: begin
                if (rd_data_reg.hash == cur_reg.key) begin
                    wr_en           = 1'b1;
                    wr_data.time_ns = cur_reg.time_ns;
                    wr_data.count   = (rd_data_reg.count == COUNT_MAX) ? COUNT_MAX
                                    : rd_data_reg.count + 32'd1;
                    state_next      = ST_FLUSH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SR_RD;
                end
            end
            ST_INSERT: begin
                emit_item.report_kind  = RPT_FIRST;
                emit_item.report_pid   = cur_reg.pid;
                emit_item.report_flags = cur_reg.flags;
                emit_item.open_count   = 32'd1;
                emit_item.key_hash     = cur_reg.key;
                emit_item.untracked    = (used_reg == CNT_W'(TABLE_DEPTH));
                if (emit_ok) begin
                    emit_fire  = 1'b1;
                    state_next = ST_FLUSH;
                    if (used_reg < CNT_W'(TABLE_DEPTH)) begin
                        wr_en           = 1'b1;
                        wr_addr         = used_reg[IDX_W-1:0];
                        wr_data.hash    = cur_reg.key;
                        wr_data.time_ns = cur_reg.time_ns;
                        wr_data.count   = 32'd1;
                        wr_data.pid     = cur_reg.pid;
                        wr_data.flags   = cur_reg.flags;
                        used_next       = used_reg + 1'b1;
                    end
                end
            end
            // exit: report pass
            ST_XR_RD: begin
                if (idx_reg >= used_reg) begin
                    idx_next   = '0;
                    state_next = ST_XD_RD;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_XR_CHK;
                end
            end
            ST_XR_CHK: begin
                emit_item.report_kind = RPT_EXIT;
                if (!(pid_hit && rd_data_reg.count > 32'd1) || emit_ok) begin
                    emit_fire  = pid_hit && (rd_data_reg.count > 32'd1);
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_XR_RD;
                end
            end
            // exit: removal pass
            ST_XD_RD: begin
                if (idx_reg >= used_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_XD_CHK;
                end
            end
            ST_XD_CHK: begin
                if (!pid_hit) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_XD_RD;
                end else if (idx_reg == last_pos) begin
                    used_next  = last_pos;
                    state_next = ST_XD_RD;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = last_pos[IDX_W-1:0];
                    state_next = ST_XD_MV;
                end
            end
            ST_XD_MV: begin
                wr_en      = 1'b1;
                used_next  = last_pos;
                state_next = ST_XD_RD;
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // one result held back so the final one can carry last
        if (emit_fire) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_item;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            window_reg     <= WINDOW_RST;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    `FODT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(TABLE_DEPTH), "table overfilled")
    `FODT_ASSERT_NOW(a_idle_clean, state_reg == ST_IDLE, !pend_valid_reg, "result left pending")
    `FODT_ASSERT_NOW(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= used_reg, "write past fill")
    `FODT_ASSERT_NOW(a_pop_idle, q_pop, state_reg == ST_IDLE, "command taken while busy")

endmodule

// ----- verif/file_open_dedup_table_unit_tb.sv -----
// Testbench for file_open_dedup_table_unit: directed and random file-open requests,
// checked against an in-bench model of the dedup table. Depends on fodt_pkg and the RTL.
module file_open_dedup_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fodt_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    file_open_dedup_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Table model: mirrors what the block should hold.
    logic [63:0] tbl_hash  [DEPTH];
    logic [63:0] tbl_time  [DEPTH];
    logic [31:0] tbl_count [DEPTH];
    logic [22:0] tbl_pid   [DEPTH];
    logic [31:0] tbl_flags [DEPTH];
    int          tbl_used;
    logic [63:0] run_hash;
    logic [22:0] cur_pid;
    logic [63:0] window;

    in_item_t  pending_reqs[$];
    out_item_t expected_reports[$];

    int mismatches = 0;
    int reports_seen = 0;
    int reqs_sent = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_send = 1'b0;
    bit in_fire = 1'b0;

    task automatic drop_slot(input int i);
        int l;
        l = tbl_used - 1;
        tbl_hash[i] = tbl_hash[l];
        tbl_time[i] = tbl_time[l];
        tbl_count[i] = tbl_count[l];
        tbl_pid[i] = tbl_pid[l];
        tbl_flags[i] = tbl_flags[l];
        tbl_used = l;
    endtask

    task automatic push_report(input rpt_kind_t k, input logic [22:0] p,
                               input logic [31:0] f, input logic [31:0] c,
                               input logic [63:0] h, input logic [63:0] t,
                               input logic u);
        out_item_t r;
        r.report_kind = k;
        r.report_pid = p;
        r.report_flags = f;
        r.open_count = c;
        r.key_hash = h;
        r.report_time_ns = t;
        r.untracked = u;
        r.last = 1'b0;
        expected_reports.push_back(r);
    endtask

    // Apply one accepted request to the table model, queueing its reports.
    task automatic track_request(input in_item_t rq);
        int i;
        int first;
        bit hit;
        out_item_t r;
        first = expected_reports.size();
        case (req_type_t'(rq.req_type))
            REQ_OPEN_BEGIN: begin
                cur_pid = rq.pid;
                run_hash = HASH_BEGIN + 64'(rq.pid);
            end
            REQ_PATH_BYTE: begin
                // zero byte terminates a C string: no effect on the hash
                if (rq.path_byte != 8'd0)
                    run_hash = run_hash * 64'd33 + 64'(signed'(rq.path_byte));
            end
            REQ_OPEN_END: begin
                i = 0;
                while (i < tbl_used) begin
                    if (rq.event_time_ns - tbl_time[i] > window) begin
                        if (tbl_count[i] > 32'd1)
                            push_report(RPT_EXPIRED, tbl_pid[i], tbl_flags[i],
                                        tbl_count[i], tbl_hash[i], rq.event_time_ns, 1'b0);
                        drop_slot(i);   // last entry moves in, recheck same slot
                    end else begin
                        i++;
                    end
                end
                hit = 1'b0;
                for (i = 0; i < tbl_used && !hit; i++) begin
                    if (tbl_hash[i] == run_hash) begin
                        if (tbl_count[i] != COUNT_MAX)
                            tbl_count[i]++;
                        tbl_time[i] = rq.event_time_ns;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (tbl_used < DEPTH) begin
                        tbl_hash[tbl_used] = run_hash;
                        tbl_time[tbl_used] = rq.event_time_ns;
                        tbl_count[tbl_used] = 32'd1;
                        tbl_pid[tbl_used] = cur_pid;
                        tbl_flags[tbl_used] = rq.open_flags;
                        tbl_used++;
                        push_report(RPT_FIRST, cur_pid, rq.open_flags, 32'd1, run_hash,
                                    rq.event_time_ns, 1'b0);
                    end else begin
                        push_report(RPT_FIRST, cur_pid, rq.open_flags, 32'd1, run_hash,
                                    rq.event_time_ns, 1'b1);
                    end
                end
            end
            default: begin
                for (i = 0; i < tbl_used; i++)
                    if (tbl_pid[i] == rq.pid && tbl_count[i] > 32'd1)
                        push_report(RPT_EXIT, tbl_pid[i], tbl_flags[i], tbl_count[i],
                                    tbl_hash[i], rq.event_time_ns, 1'b0);
                i = 0;
                while (i < tbl_used) begin
                    if (tbl_pid[i] == rq.pid) drop_slot(i);
                    else i++;
                end
            end
        endcase
        if (expected_reports.size() > first) begin
            r = expected_reports[$];
            r.last = 1'b1;
            expected_reports[expected_reports.size() - 1] = r;
        end
    endtask

    // Request handshake registered at the rising edge for the driver, which acts on the falling edge.
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
    end

    // Driver: request channel, changes on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                track_request(s_data);
                reqs_sent++;
                void'(pending_reqs.pop_front());
            end
            if (in_fire || !s_valid) begin
                if (pending_reqs.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: sample reports at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            reports_seen <= reports_seen + 1;
            if (expected_reports.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: unexpected report %p", m_data);
            end else begin
                if (m_data !== expected_reports[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: report mismatch\n  exp %p\n  got %p",
                                 expected_reports[0], m_data);
                end
                void'(expected_reports.pop_front());
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout, %0d reports still pending", expected_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_item_t mk(input req_type_t k, input logic [22:0] p,
                                    input logic [7:0] b, input logic [31:0] f,
                                    input logic [63:0] t);
        in_item_t rq;
        rq.req_type = k;
        rq.pid = p;
        rq.path_byte = b;
        rq.open_flags = f;
        rq.event_time_ns = t;
        return rq;
    endfunction

    // Random request: mostly complete opens over a small pid/path pool so hits,
    // expiry and exits all happen; some stray requests as noise.
    logic [63:0] now_ns = 64'd1000;

    task automatic queue_random_open();
        int n;
        logic [22:0] p;
        p = ($urandom_range(9) == 0) ? 23'($urandom_range(1, 4194304))
                                     : 23'($urandom_range(1, 6));
        pending_reqs.push_back(mk(REQ_OPEN_BEGIN, p, 8'($urandom), $urandom, $urandom));
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(mk(REQ_PATH_BYTE, 23'($urandom),
                ($urandom_range(1) == 0) ? 8'($urandom_range(0, 3) * 8'h41) : 8'($urandom),
                $urandom, $urandom));
        now_ns += 64'($urandom_range(0, 400));
        if ($urandom_range(19) == 0) now_ns = {$urandom, $urandom};
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'($urandom), 8'($urandom), $urandom, now_ns));
    endtask

    task automatic fill_random(input int n_items);
        int start;
        start = pending_reqs.size();
        while (pending_reqs.size() - start < n_items) begin
            case ($urandom_range(19))
                0: pending_reqs.push_back(mk(REQ_EXIT, 23'($urandom_range(1, 6)),
                       8'($urandom), $urandom, now_ns));
                1: pending_reqs.push_back(mk(req_type_t'($urandom_range(3)),
                       23'($urandom), 8'($urandom), $urandom, {$urandom, $urandom}));
                default: queue_random_open();
            endcase
        end
    endtask

    // Wait for the block to drain, plus slack for engine passes with no report.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic set_window(input logic [63:0] w);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        window = w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        tbl_used = 0;
        run_hash = HASH_SEED;
        cur_pid = '0;
        window = WINDOW_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: end without begin, byte extremes, zero byte, repeat end,
        // time going backwards, exit of a pid, field extremes.
        send_idle_pct = 31;
        recv_idle_pct = 74;
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'h8000_0000, 64'd0));
        pending_reqs.push_back(mk(REQ_OPEN_BEGIN, 23'd4194304, 8'd0, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_PATH_BYTE, 23'h7FFFFF, 8'hFF, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_PATH_BYTE, 23'd0, 8'h80, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_PATH_BYTE, 23'd0, 8'h7F, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_PATH_BYTE, 23'd0, 8'h00, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'h7FFF_FFFF, 64'd100));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'hFFFF_FFFF, 64'd200));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'd5, 64'd300));
        pending_reqs.push_back(mk(REQ_OPEN_BEGIN, 23'd1, 8'd0, 32'd0, 64'd0));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'd1, 64'd400));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'd1, 64'd50));
        pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(mk(REQ_EXIT, 23'd4194304, 8'd0, 32'd0, 64'd500));
        pending_reqs.push_back(mk(REQ_EXIT, 23'd1, 8'd0, 32'd0, 64'd600));
        // three more opens with distinct pids and keys
        for (int k = 0; k < 3; k++) begin
            pending_reqs.push_back(mk(REQ_OPEN_BEGIN, 23'(100 + k), 8'd0, 32'd0, 64'd0));
            pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'(k), 64'(700 + k)));
        end
        drain();

        // Huge window: table fills and stays full.
        set_window(64'hFFFF_FFFF_FFFF_FFFF);
        for (int k = 0; k < 36; k++) begin
            pending_reqs.push_back(mk(REQ_OPEN_BEGIN, 23'(200 + k), 8'd0, 32'd0, 64'd0));
            pending_reqs.push_back(mk(REQ_OPEN_END, 23'd0, 8'd0, 32'(k), 64'(1000 + k)));
        end
        fill_random(40);
        drain();

        // Zero window: every entry whose time differs from the next end's expires on that end.
        set_window(64'd0);
        send_idle_pct = 74;
        recv_idle_pct = 31;
        fill_random(70);
        // hold-off: let every queued report come out before more requests
        hold_send = 1'b1;
        while (s_valid || expected_reports.size() > 0) @(posedge aclk);
        hold_send = 1'b0;
        fill_random(40);
        drain();

        // Mid window, then no idling at all.
        set_window(64'd500);
        fill_random(70);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(64'd1500);
        fill_random(70);
        drain();

        $display("Run covered %0d requests and %0d reports across five window settings,",
                 reqs_sent, reports_seen);
        $display("including full-table, expiry, exit and idle/stall patterns.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fodt_pkg.sv
rtl/fodt_front.sv
rtl/fodt_queue.sv
rtl/fodt_engine.sv
rtl/file_open_dedup_table_unit.sv
verif/file_open_dedup_table_unit_tb.sv
